// ===== hdl/plic_pkg.sv =====
package plic_pkg;

  localparam int LANES      = 64;
  localparam int HOLD_WIDTH = 16;
  localparam int RX_BITS    = 8;
  localparam int LANE_W     = 6;

  localparam logic [HOLD_WIDTH-1:0] HIGH_TICKS_RESET = HOLD_WIDTH'(50);
  localparam logic [HOLD_WIDTH-1:0] LOW_TICKS_RESET  = HOLD_WIDTH'(75);

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  localparam logic REG_HIGH_TICKS = 1'b0;
  localparam logic REG_LOW_TICKS  = 1'b1;

  typedef enum logic [25:0] {
    PH_IDLE = 26'h0000001,
    S_SDAH  = 26'h0000002,
    S_WH1   = 26'h0000004,
    S_SCLH  = 26'h0000008,
    S_WH2   = 26'h0000010,
    S_SDAL  = 26'h0000020,
    S_WL    = 26'h0000040,
    S_SCLL  = 26'h0000080,
    P_SDAL  = 26'h0000100,
    P_WL    = 26'h0000200,
    P_SCLH  = 26'h0000400,
    P_WH    = 26'h0000800,
    P_SDAH  = 26'h0001000,
    T_SDA   = 26'h0002000,
    T_SCLH  = 26'h0004000,
    T_SCLL  = 26'h0008000,
    T_REL   = 26'h0010000,
    T_ACKH  = 26'h0020000,
    T_ACKL  = 26'h0040000,
    R_REL   = 26'h0080000,
    R_SCLH  = 26'h0100000,
    R_SCLL  = 26'h0200000,
    R_ACK   = 26'h0400000,
    R_ACKH  = 26'h0800000,
    R_ACKL  = 26'h1000000,
    R_REL2  = 26'h2000000
  } phase_t;

  typedef struct packed {
    logic clear;
    logic shift_in;
    logic rotate;
  } rx_ctrl_t;

endpackage

// ===== hdl/plic_rx_lanes.sv =====
module plic_rx_lanes
  import plic_pkg::*;
(
  input  logic                 clk,
  input  rx_ctrl_t             ctrl,
  input  logic [LANES-1:0]     sda,
  output logic [RX_BITS-1:0]   lane0_byte
);

  // plane[j] holds bit j of every lane's receive shift register
  logic [LANES-1:0] plane [RX_BITS];

  always_ff @(posedge clk) begin
    for (int j = 0; j < RX_BITS; j++) begin
      if (ctrl.clear) begin
        plane[j] <= '0;
      end else if (ctrl.shift_in) begin
        if (j == 0) begin
          plane[j] <= sda;
        end else begin
          plane[j] <= plane[j-1];
        end
      end else if (ctrl.rotate) begin
        // next lane moves down to bit 0
        plane[j] <= plane[j] >> 1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < RX_BITS; j++) begin
      lane0_byte[j] = plane[j][0];
    end
  end

endmodule

// ===== hdl/parallel_lane_i2c_master.sv =====
// Each accepted tick's result beat is registered and presented the cycle after.
// One tick per cycle while the output register is free or its last beat leaves.
// A receive completion gives 64 beats, one per cycle while out_ready is high,
// lanes shifted out of the bit planes; no tick is taken until the last leaves.
// Synchronous active-high reset: idle, lines released, holds 50 and 75, no beat.
module parallel_lane_i2c_master
  import plic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [HOLD_WIDTH-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            cmd,
  input  logic [7:0]            tx_byte,
  input  logic                  send_ack,
  input  logic [LANES-1:0]      sda_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  scl_level,
  output logic                  sda_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [LANE_W-1:0]     lane,
  output logic [RX_BITS-1:0]    rx_byte,
  output logic [LANES-1:0]      ack_bits,
  output logic                  error_flag,
  output logic                  last
);

  logic [HOLD_WIDTH-1:0] high_ticks, low_ticks;
  phase_t                phase, phase_next, nx;
  logic [HOLD_WIDTH-1:0] hold_count, hold_next;
  logic [3:0]            bit_index, bit_next;
  logic [7:0]            tx_shift, tx_next;
  logic [LANES-1:0]      ack_store, ack_next;
  logic                  nack_seen, nack_next;
  logic                  ack_choice, choice_next;
  logic                  scl_drive, scl_next;
  logic                  sda_drive, sda_next;
  logic                  done, rx_done, enter, finish, level;
  logic                  in_take, out_take;
  rx_ctrl_t              rx_ctrl;
  logic [RX_BITS-1:0]    lane0_byte;

  assign in_ready = !out_valid || (out_ready && last);
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_comb begin
    phase_next  = phase;
    hold_next   = hold_count;
    bit_next    = bit_index;
    tx_next     = tx_shift;
    ack_next    = ack_store;
    nack_next   = nack_seen;
    choice_next = ack_choice;
    scl_next    = scl_drive;
    sda_next    = sda_drive;
    done        = 1'b0;
    rx_done     = 1'b0;
    enter       = 1'b0;
    finish      = 1'b0;
    level       = 1'b1;
    nx          = PH_IDLE;
    rx_ctrl     = '0;

    if (phase == PH_IDLE) begin
      case (cmd)
        CMD_START: begin
          nx    = S_SDAH;
          enter = 1'b1;
        end
        CMD_STOP: begin
          nx    = P_SDAL;
          enter = 1'b1;
        end
        CMD_SEND: begin
          tx_next  = tx_byte;
          bit_next = '0;
          nx       = T_SDA;
          enter    = 1'b1;
        end
        CMD_RECV: begin
          choice_next   = send_ack;
          bit_next      = '0;
          rx_ctrl.clear = 1'b1;
          nx            = R_REL;
          enter         = 1'b1;
        end
        CMD_CLEAR: begin
          nack_next = 1'b0;
          done      = 1'b1;
        end
        default: ;
      endcase
    end else if (hold_count != '0) begin
      hold_next = hold_count - HOLD_WIDTH'(1);
    end else begin
      enter = 1'b1;
      case (phase)
        S_SCLL, P_SDAH, T_ACKL, R_REL2: begin
          enter  = 1'b0;
          finish = 1'b1;
        end
        S_SDAH: nx = S_WH1;
        S_WH1:  nx = S_SCLH;
        S_SCLH: nx = S_WH2;
        S_WH2:  nx = S_SDAL;
        S_SDAL: nx = S_WL;
        S_WL:   nx = S_SCLL;
        P_SDAL: nx = P_WL;
        P_WL:   nx = P_SCLH;
        P_SCLH: nx = P_WH;
        P_WH:   nx = P_SDAH;
        T_SDA:  nx = T_SCLH;
        T_SCLH: nx = T_SCLL;
        T_SCLL: begin
          bit_next = bit_index + 4'd1;
          tx_next  = {tx_shift[6:0], 1'b0};
          nx       = (bit_next < 4'd8) ? T_SDA : T_REL;
        end
        T_REL:  nx = T_ACKH;
        T_ACKH: begin
          ack_next = sda_sample;
          if (sda_sample != '0) begin
            nack_next = 1'b1;
          end
          nx = T_ACKL;
        end
        R_REL:  nx = R_SCLH;
        R_SCLH: begin
          rx_ctrl.shift_in = 1'b1;
          nx               = R_SCLL;
        end
        R_SCLL: begin
          bit_next = bit_index + 4'd1;
          nx       = (bit_next < 4'd8) ? R_SCLH : R_ACK;
        end
        R_ACK:  nx = R_ACKH;
        R_ACKH: nx = R_ACKL;
        R_ACKL: nx = R_REL2;
        default: begin
          enter  = 1'b0;
          finish = 1'b1;
        end
      endcase
    end

    if (finish) begin
      phase_next = PH_IDLE;
      hold_next  = '0;
      done       = 1'b1;
      rx_done    = (phase == R_REL2);
    end

    if (enter) begin
      phase_next = nx;
      case (nx)
        S_SDAH, P_SDAH, T_REL, R_REL, R_REL2: begin
          sda_next = 1'b1;
          level    = 1'b1;
        end
        S_SDAL, P_SDAL: begin
          sda_next = 1'b0;
          level    = 1'b0;
        end
        S_SCLH, P_SCLH, T_SCLH, T_ACKH, R_SCLH, R_ACKH: begin
          scl_next = 1'b1;
          level    = 1'b1;
        end
        S_SCLL, T_SCLL, T_ACKL, R_SCLL, R_ACKL: begin
          scl_next = 1'b0;
          level    = 1'b0;
        end
        S_WH1, S_WH2, P_WH: level = 1'b1;
        S_WL, P_WL:         level = 1'b0;
        T_SDA: begin
          sda_next = tx_next[7];
          level    = tx_next[7];
        end
        R_ACK: begin
          sda_next = !choice_next;
          level    = !choice_next;
        end
        default: level = 1'b1;
      endcase
      hold_next = level ? high_ticks : low_ticks;
    end

    if (!in_take) begin
      rx_ctrl.clear    = 1'b0;
      rx_ctrl.shift_in = 1'b0;
    end
    // lanes leave the planes one per beat
    rx_ctrl.rotate = (in_take && rx_done) || (out_take && !last);
  end

  plic_rx_lanes u_rx_lanes (
    .clk        (clk),
    .ctrl       (rx_ctrl),
    .sda        (sda_sample),
    .lane0_byte (lane0_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      high_ticks <= HIGH_TICKS_RESET;
      low_ticks  <= LOW_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_TICKS: high_ticks <= cfg_data;
        REG_LOW_TICKS:  low_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
      bit_index  <= '0;
      tx_shift   <= '0;
      ack_store  <= '0;
      nack_seen  <= 1'b0;
      ack_choice <= 1'b0;
      scl_drive  <= 1'b1;
      sda_drive  <= 1'b1;
    end else if (in_take) begin
      phase      <= phase_next;
      hold_count <= hold_next;
      bit_index  <= bit_next;
      tx_shift   <= tx_next;
      ack_store  <= ack_next;
      nack_seen  <= nack_next;
      ack_choice <= choice_next;
      scl_drive  <= scl_next;
      sda_drive  <= sda_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_take && last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      scl_level  <= scl_next;
      sda_level  <= sda_next;
      busy_res   <= (phase_next != PH_IDLE);
      done_res   <= done;
      ack_bits   <= ack_next;
      error_flag <= nack_next;
      lane       <= '0;
      rx_byte    <= rx_done ? lane0_byte : '0;
      last       <= !rx_done || (LANES == 1);
    end else if (out_take && !last) begin
      lane    <= lane + LANE_W'(1);
      rx_byte <= lane0_byte;
      last    <= ((lane + LANE_W'(1)) == LANE_W'(LANES - 1));
    end
  end

endmodule

// ===== tb/parallel_lane_i2c_master_tb.sv =====
module parallel_lane_i2c_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plic_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // sda_sample patterns for the ticks of a running command
  localparam int SAMP_FIXED  = 0;
  localparam int SAMP_RANDOM = 1;
  localparam int SAMP_MIXED  = 2;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                scl;
    logic                sda;
    logic                busy;
    logic                done;
    logic [LANE_W-1:0]   lane;
    logic [RX_BITS-1:0]  rx;
    logic [LANES-1:0]    ack;
    logic                err;
    logic                last;
  } bus_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_HIGH_TICKS;
  logic [HOLD_WIDTH-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            cmd = CMD_TICK;
  logic [7:0]            tx_byte = '0;
  logic                  send_ack = 1'b0;
  logic [LANES-1:0]      sda_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  scl_level;
  logic                  sda_level;
  logic                  busy_res;
  logic                  done_res;
  logic [LANE_W-1:0]     lane;
  logic [RX_BITS-1:0]    rx_byte;
  logic [LANES-1:0]      ack_bits;
  logic                  error_flag;
  logic                  last;

  parallel_lane_i2c_master DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_sample (sda_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .lane       (lane),
    .rx_byte    (rx_byte),
    .ack_bits   (ack_bits),
    .error_flag (error_flag),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // master state as the block should hold it
  logic [HOLD_WIDTH-1:0] pr_high = HIGH_TICKS_RESET;
  logic [HOLD_WIDTH-1:0] pr_low  = LOW_TICKS_RESET;
  phase_t                pr_phase = PH_IDLE;
  logic [HOLD_WIDTH-1:0] pr_hold = '0;
  logic [3:0]            pr_bit = '0;
  logic [7:0]            pr_tx = '0;
  logic [7:0]            pr_rx [LANES] = '{default: '0};
  logic [LANES-1:0]      pr_ack = '0;
  logic                  pr_nack = 1'b0;
  logic                  pr_ack_choice = 1'b0;
  logic                  pr_scl = 1'b1;
  logic                  pr_sda = 1'b1;

  bus_beat_t beats_due [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        cmds_issued = 0;
  bit        tx_gaps = 1'b0;
  bit        rx_gaps = 1'b0;
  int        stall_request = 0;

  function automatic void line_sda(input logic v);
    pr_sda  = v;
    pr_hold = v ? pr_high : pr_low;
  endfunction

  function automatic void line_scl(input logic v);
    pr_scl  = v;
    pr_hold = v ? pr_high : pr_low;
  endfunction

  function automatic void step_enter(input phase_t p);
    pr_phase = p;
    case (p)
      S_SDAH, P_SDAH, T_REL, R_REL, R_REL2:         line_sda(1'b1);
      S_SDAL, P_SDAL:                               line_sda(1'b0);
      S_SCLH, P_SCLH, T_SCLH, T_ACKH, R_SCLH, R_ACKH: line_scl(1'b1);
      S_SCLL, T_SCLL, T_ACKL, R_SCLL, R_ACKL:       line_scl(1'b0);
      S_WH1, S_WH2, P_WH:                           pr_hold = pr_high;
      S_WL, P_WL:                                   pr_hold = pr_low;
      T_SDA:                                        line_sda(pr_tx[7 - pr_bit[2:0]]);
      R_ACK:                                        line_sda(!pr_ack_choice);
      default: begin
        pr_phase = PH_IDLE;
        pr_hold  = '0;
      end
    endcase
  endfunction

  // end of the current step; PH_IDLE once the command is over
  function automatic phase_t step_finish(input logic [LANES-1:0] s);
    int k;
    case (pr_phase)
      S_SCLL, P_SDAH, T_ACKL, R_REL2: return PH_IDLE;
      T_SCLL: begin
        pr_bit++;
        return (pr_bit < 4'd8) ? T_SDA : T_REL;
      end
      T_ACKH: begin
        pr_ack = s;
        if (s != '0) pr_nack = 1'b1;
        return T_ACKL;
      end
      R_SCLH: begin
        for (k = 0; k < LANES; k++) pr_rx[k] = {pr_rx[k][6:0], s[k]};
        return R_SCLL;
      end
      R_SCLL: begin
        pr_bit++;
        return (pr_bit < 4'd8) ? R_SCLH : R_ACK;
      end
      // one-hot codes follow the step order, so the next step is one bit up
      default: return phase_t'(pr_phase << 1);
    endcase
  endfunction

  function automatic void master_tick(input logic [2:0] c, input logic [7:0] b,
                                      input logic a, input logic [LANES-1:0] s);
    logic      done;
    logic      rx_done;
    phase_t    was;
    phase_t    nx;
    bus_beat_t bt;
    int        n;
    int        k;
    done    = 1'b0;
    rx_done = 1'b0;
    if (pr_phase == PH_IDLE) begin
      case (c)
        CMD_START: step_enter(S_SDAH);
        CMD_STOP:  step_enter(P_SDAL);
        CMD_SEND: begin
          pr_tx  = b;
          pr_bit = '0;
          step_enter(T_SDA);
        end
        CMD_RECV: begin
          pr_ack_choice = a;
          pr_bit = '0;
          for (k = 0; k < LANES; k++) pr_rx[k] = '0;
          step_enter(R_REL);
        end
        CMD_CLEAR: begin
          pr_nack = 1'b0;
          done    = 1'b1;
        end
        default: ;
      endcase
    end else if (pr_hold != '0) begin
      pr_hold--;
    end else begin
      was = pr_phase;
      nx  = step_finish(s);
      if (nx == PH_IDLE) begin
        pr_phase = PH_IDLE;
        pr_hold  = '0;
        done     = 1'b1;
        rx_done  = (was == R_REL2);
      end else begin
        step_enter(nx);
      end
    end
    n = rx_done ? LANES : 1;
    for (k = 0; k < n; k++) begin
      bt.scl  = pr_scl;
      bt.sda  = pr_sda;
      bt.busy = (pr_phase != PH_IDLE);
      bt.done = done;
      bt.lane = rx_done ? LANE_W'(k) : '0;
      bt.rx   = rx_done ? pr_rx[k] : '0;
      bt.ack  = pr_ack;
      bt.err  = pr_nack;
      bt.last = (k == n - 1);
      beats_due.push_back(bt);
    end
  endfunction

  function automatic logic [LANES-1:0] pick_sample(input int mode,
                                                   input logic [LANES-1:0] fixed);
    int r;
    if (mode == SAMP_FIXED) return fixed;
    if (mode == SAMP_RANDOM) return {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r < 5) return '0;
    if (r < 6) return '1;
    if (r < 8) return LANES'(1) << $urandom_range(0, LANES - 1);
    return {$urandom, $urandom};
  endfunction

  task automatic send_tick(input logic [2:0] c, input logic [7:0] b, input logic a,
                           input logic [LANES-1:0] s);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    tx_byte    <= b;
    send_ack   <= a;
    sda_sample <= s;
    do @(posedge clk); while (!in_ready);
    master_tick(c, b, a, s);
  endtask

  // issue a command, then tick until it is over; busy ticks carry junk commands
  task automatic run_cmd(input logic [2:0] c, input logic [7:0] b, input logic a,
                         input int mode, input logic [LANES-1:0] fixed);
    send_tick(c, b, a, pick_sample(mode, fixed));
    cmds_issued++;
    while (pr_phase != PH_IDLE)
      send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                pick_sample(mode, fixed));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
  endtask

  task automatic set_holds(input logic [HOLD_WIDTH-1:0] h, input logic [HOLD_WIDTH-1:0] l);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_HIGH_TICKS;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_LOW_TICKS;
    cfg_data  <= l;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pr_high = h;
    pr_low  = l;
  endtask

  function automatic void check_field(input string f, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, f, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_beat();
    bus_beat_t want;
    if (beats_due.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual lane %0d rx %0h",
               $time, lane, rx_byte);
      mismatches++;
      return;
    end
    want = beats_due.pop_front();
    check_field("scl_level", 64'(want.scl), 64'(scl_level));
    check_field("sda_level", 64'(want.sda), 64'(sda_level));
    check_field("busy_res", 64'(want.busy), 64'(busy_res));
    check_field("done_res", 64'(want.done), 64'(done_res));
    check_field("lane", 64'(want.lane), 64'(lane));
    check_field("rx_byte", 64'(want.rx), 64'(rx_byte));
    check_field("ack_bits", 64'(want.ack), 64'(ack_bits));
    check_field("error_flag", 64'(want.err), 64'(error_flag));
    check_field("last", 64'(want.last), 64'(last));
  endfunction

  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_beat();
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_gaps && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_reset_holds();
    run_cmd(CMD_CLEAR, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_START, 8'hFF, 1'b1, SAMP_RANDOM, '0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_RANDOM, '0);
  endtask

  // nothing here starts a sequence, so the huge holds never run
  task automatic test_idle_codes();
    set_holds('1, '1);
    run_cmd(CMD_TICK, 8'hFF, 1'b1, SAMP_FIXED, '1);
    run_cmd(CMD_CLEAR, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_SPARE_6, 8'hFF, 1'b1, SAMP_FIXED, '0);
    run_cmd(CMD_SPARE_7, 8'h00, 1'b0, SAMP_FIXED, '1);
  endtask

  task automatic test_send_ack();
    set_holds('0, '0);
    run_cmd(CMD_START, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_SEND, 8'hFF, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_SEND, 8'h00, 1'b1, SAMP_FIXED, '1);
    run_cmd(CMD_CLEAR, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_SEND, 8'hA5, 1'b0, SAMP_FIXED, LANES'(1) << (LANES - 1));
    run_cmd(CMD_SEND, 8'h5A, 1'b1, SAMP_FIXED, LANES'(1));
    run_cmd(CMD_CLEAR, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_FIXED, '0);
  endtask

  task automatic test_receive();
    set_holds(16'd1, 16'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, SAMP_FIXED, '0);
    run_cmd(CMD_RECV, 8'h00, 1'b1, SAMP_RANDOM, '0);
    run_cmd(CMD_RECV, 8'hFF, 1'b0, SAMP_FIXED, '1);
    run_cmd(CMD_RECV, 8'h00, 1'b1, SAMP_FIXED, '0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_FIXED, '0);
  endtask

  task automatic test_no_start();
    set_holds(16'd0, 16'd1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_RANDOM, '0);
    run_cmd(CMD_SEND, 8'h81, 1'b0, SAMP_MIXED, '0);
    run_cmd(CMD_RECV, 8'h00, 1'b0, SAMP_RANDOM, '0);
  endtask

  // mostly framed transfers with random content, some loose or junk commands
  task automatic random_transfers(input int budget, input bit with_gaps);
    int base;
    int k;
    int n;
    base = cmds_issued;
    while (cmds_issued - base < budget) begin
      tx_gaps = with_gaps && ($urandom_range(0, 3) != 0);
      rx_gaps = with_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 5) == 0)
          set_holds(HOLD_WIDTH'($urandom_range(0, 8)), HOLD_WIDTH'($urandom_range(0, 8)));
        else
          set_holds(HOLD_WIDTH'($urandom_range(0, 2)), HOLD_WIDTH'($urandom_range(0, 2)));
      end
      if ($urandom_range(0, 9) < 7) begin
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), SAMP_MIXED, '0);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 0)
            run_cmd(CMD_SEND, 8'($urandom), 1'($urandom), SAMP_MIXED, '0);
          else
            run_cmd(CMD_RECV, 8'($urandom), 1'($urandom), SAMP_RANDOM, '0);
        end
        if ($urandom_range(0, 5) != 0)
          run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SAMP_MIXED, '0);
      end else begin
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SAMP_MIXED, '0);
      end
    end
  endtask

  task automatic test_random();
    random_transfers(180, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_holds('0, '0);
    run_cmd(CMD_START, 8'h00, 1'b0, SAMP_FIXED, '0);
    stall_request = 300;
    run_cmd(CMD_RECV, 8'h00, 1'b1, SAMP_RANDOM, '0);
    run_cmd(CMD_SEND, 8'($urandom), 1'b0, SAMP_MIXED, '0);
    wait_drained();
    run_cmd(CMD_RECV, 8'h00, 1'b0, SAMP_RANDOM, '0);
    stall_request = 150;
    run_cmd(CMD_RECV, 8'h00, 1'b1, SAMP_RANDOM, '0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_FIXED, '0);
    wait_drained();
  endtask

  task automatic test_no_idle();
    random_transfers(30, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
  endtask

  // two low holds at the counter's full range
  task automatic test_long_hold();
    set_holds('0, '1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SAMP_RANDOM, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_holds();
    test_idle_codes();
    test_send_ack();
    test_receive();
    test_no_start();
    test_random();
    test_backpressure();
    test_no_idle();
    test_long_hold();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
